// File: hw/rtl/awpa_pkg.sv
// Package: shared types, constants and state encoding for the pixel average unit.
package awpa_pkg;

    localparam int AREA_W  = 24;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 7;
    localparam int WSUM_W  = 64;
    localparam int ASUM_W  = 30;
    localparam int QUO_W   = 64;
    localparam int DEF_MAX_OVERLAPS = 64;

    localparam logic signed [VAL_W-1:0] INIT_MIN = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] INIT_MAX = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_OUTPUT
    } awpa_state_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic take;      // absorb the accepted item
        logic start_div; // latch result inputs and start the divider
        logic div_step;  // one quotient bit
        logic out_pop;   // result taken downstream
    } awpa_cmd_t;

    // Datapath status to the controller.
    typedef struct packed {
        logic div_done;
    } awpa_sts_t;

endpackage

// File: hw/rtl/awpa_ctrl.sv
// Controller state machine: accumulate, divide, present result.
module awpa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             item_last,   // item closes a pixel (last or empty)
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output awpa_pkg::awpa_cmd_t cmd,
    input  awpa_pkg::awpa_sts_t sts
);
    import awpa_pkg::*;

    awpa_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM: begin
                if (s_tvalid && item_last) state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (sts.div_done) state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (m_tready) state_next = ST_ACCUM;
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == ST_ACCUM);
        m_tvalid      = (state_reg == ST_OUTPUT);
        cmd.take      = s_tready && s_tvalid;
        cmd.start_div = s_tready && s_tvalid && item_last;
        cmd.div_step  = (state_reg == ST_DIVIDE) && !sts.div_done;
        cmd.out_pop   = m_tvalid && m_tready;
    end

endmodule

// File: hw/rtl/awpa_datapath.sv
// Datapath: accumulators, bit-serial signed divider and result register.
module awpa_datapath #(
    parameter int MAX_OVERLAPS = awpa_pkg::DEF_MAX_OVERLAPS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [awpa_pkg::VAL_W-1:0]   miss_value,
    input  logic        [awpa_pkg::AREA_W-1:0]  rec_area,
    input  logic signed [awpa_pkg::VAL_W-1:0]   sample_value,
    input  logic                                sample_masked,
    input  logic                                sample_invalid,
    input  logic                                pixel_empty,
    input  logic                                last_of_pixel,
    input  awpa_pkg::awpa_cmd_t                 cmd,
    output awpa_pkg::awpa_sts_t                 sts,
    output logic signed [awpa_pkg::VAL_W-1:0]   mean_value,
    output logic signed [awpa_pkg::VAL_W-1:0]   min_value,
    output logic signed [awpa_pkg::VAL_W-1:0]   max_value,
    output logic        [awpa_pkg::CNT_W-1:0]   accepted_count,
    output logic                                has_data
);
    import awpa_pkg::*;

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic signed [WSUM_W-1:0] wsum_reg, wsum_next;
    logic        [ASUM_W-1:0] asum_reg, asum_next;
    logic signed [VAL_W-1:0]  min_reg, min_next, max_reg, max_next;
    logic        [CNT_W-1:0]  cnt_reg, cnt_next;
    logic                     use_sample;
    logic signed [VAL_W+AREA_W:0] product;

    // Divider: magnitude restoring division, one quotient bit a cycle.
    logic [QUO_W-1:0]  quo_reg;
    logic [ASUM_W:0]   rem_reg;
    logic [ASUM_W-1:0] dvs_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [ASUM_W+1:0] trial;
    logic [WSUM_W-1:0] wmag;
    logic [QUO_W-1:0]  quo_signed;

    assign use_sample = !sample_masked && !sample_invalid && (sample_value != miss_value)
                        && (cnt_reg < CNT_W'(MAX_OVERLAPS));
    assign product = $signed({1'b0, rec_area}) * sample_value;

    always_comb begin
        wsum_next = wsum_reg;
        asum_next = asum_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        cnt_next  = cnt_reg;
        if (use_sample) begin
            wsum_next = wsum_reg + WSUM_W'(product);
            asum_next = asum_reg + ASUM_W'(rec_area);
            if (sample_value < min_reg) min_next = sample_value;
            if (sample_value > max_reg) max_next = sample_value;
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsum_reg <= '0;
            asum_reg <= '0;
            min_reg  <= INIT_MIN;
            max_reg  <= INIT_MAX;
            cnt_reg  <= '0;
        end else if (cmd.take) begin
            if (pixel_empty || last_of_pixel) begin
                wsum_reg <= '0;
                asum_reg <= '0;
                min_reg  <= INIT_MIN;
                max_reg  <= INIT_MAX;
                cnt_reg  <= '0;
            end else begin
                wsum_reg <= wsum_next;
                asum_reg <= asum_next;
                min_reg  <= min_next;
                max_reg  <= max_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    assign wmag  = wsum_next[WSUM_W-1] ? (~wsum_next + 1'b1) : wsum_next;
    assign trial = {rem_reg, quo_reg[QUO_W-1]} - {2'b00, dvs_reg};
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= '0;
        end else if (cmd.start_div) begin
            // Empty pixel or zero area sum: no division, result is fill.
            steps_reg <= (pixel_empty || asum_next == '0) ? '0 : STEP_W'(QUO_W);
        end else if (cmd.div_step) begin
            steps_reg <= steps_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_div) begin
            quo_reg        <= wmag;
            rem_reg        <= '0;
            dvs_reg        <= asum_next;
            neg_reg        <= wsum_next[WSUM_W-1];
            has_data       <= !pixel_empty && (asum_next != '0);
            min_value      <= pixel_empty ? INIT_MIN : min_next;
            max_value      <= pixel_empty ? INIT_MAX : max_next;
            accepted_count <= pixel_empty ? '0 : cnt_next;
        end else if (cmd.div_step) begin
            if (!trial[ASUM_W+1]) begin
                rem_reg <= trial[ASUM_W:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[ASUM_W-1:0], quo_reg[QUO_W-1]};
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign sts.div_done = (steps_reg == '0);
    assign mean_value   = has_data ? quo_signed[VAL_W-1:0] : miss_value;

endmodule

// File: hw/rtl/area_weighted_pixel_average_unit.sv
// Top level: area-weighted pixel average with stream ports and fill register.
//
//  channel   direction  payload
//  s_        in         overlap record, one per item
//  m_        out        pixel result, one per pixel
//  cfg_      in         fill register write
//
// Non-closing records are accepted back to back. A closing record (last or empty)
// hands off to the bit-serial divider: 64 quotient steps, then the result is held
// on m_ until taken. Empty pixels and zero-area pixels skip the quotient steps.
// Reset (aresetn low, synchronous) returns the accumulators to their start
// values and clears the fill register to 0.
// s_tready stays low from a closing record until its result is taken.
module area_weighted_pixel_average_unit #(
    parameter int MAX_OVERLAPS = awpa_pkg::DEF_MAX_OVERLAPS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // [23:0] area, [55:24] sample_value, zero pad
    input  logic [2:0]  s_tuser,  // [0] sample_masked, [1] sample_invalid, [2] pixel_empty
    input  logic        s_tlast,  // last_of_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [103:0] m_tdata, // mean[31:0], min[63:32], max[95:64], count[102:96], pad
    output logic        m_tuser,  // has_data
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import awpa_pkg::*;

    awpa_cmd_t cmd;
    awpa_sts_t sts;
    logic signed [VAL_W-1:0] fill_reg;
    logic signed [VAL_W-1:0] mean_value, min_value, max_value;
    logic [CNT_W-1:0] accepted_count;
    logic has_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cfg_valid) begin
            fill_reg <= cfg_data;
        end
    end

    awpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .item_last (s_tlast || s_tuser[2]),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    awpa_datapath #(.MAX_OVERLAPS(MAX_OVERLAPS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .miss_value     (fill_reg),
        .rec_area       (s_tdata[23:0]),
        .sample_value   (s_tdata[55:24]),
        .sample_masked  (s_tuser[0]),
        .sample_invalid (s_tuser[1]),
        .pixel_empty    (s_tuser[2]),
        .last_of_pixel  (s_tlast),
        .cmd            (cmd),
        .sts            (sts),
        .mean_value     (mean_value),
        .min_value      (min_value),
        .max_value      (max_value),
        .accepted_count (accepted_count),
        .has_data       (has_data)
    );

    assign m_tdata = {1'b0, accepted_count, max_value, min_value, mean_value};
    assign m_tuser = has_data;

    // Never accept input while a result is pending.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input open during output");
    // A closing record must stop the input the next cycle.
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tlast || s_tuser[2])) |=> !s_tready)
        else $error("input not stalled after closing item");
    // Count never exceeds the limit.
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (accepted_count <= CNT_W'(MAX_OVERLAPS)))
        else $error("count over limit");

endmodule
